[src/iah_pkg.sv]
// ============================================================================
// Inter-arrival histogram package
// Shared widths, constants and register codes of the inter-arrival histogram.
// ============================================================================
`default_nettype none

package iah_pkg;

   localparam int BIN_COUNT_DEFAULT   = 128;
   localparam int COUNT_WIDTH_DEFAULT = 32;

   // Field widths of the request and response transactions.
   localparam int STAMP_SEC_WIDTH  = 32;
   localparam int STAMP_NS_WIDTH   = 30;
   localparam int READ_INDEX_WIDTH = 7;
   localparam int BIN_INDEX_WIDTH  = 7;
   localparam int BIN_COUNT_WIDTH  = 32;

   // Configuration port.
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int MIN_WIDTH       = 32;
   localparam int SCALE_WIDTH     = 32;
   localparam int BINS_WIDTH      = 8;

   localparam logic [MIN_WIDTH-1:0]   MIN_RESET   = 32'd500000;
   localparam logic [SCALE_WIDTH-1:0] SCALE_RESET = 32'd16915563;
   localparam logic [BINS_WIDTH-1:0]  BINS_RESET  = 8'd100;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CFG_MIN_INTERVAL = 2'd0,
      CFG_BIN_SCALE    = 2'd1,
      CFG_BINS_IN_USE  = 2'd2
   } cfg_index_type;

   typedef enum logic {
      OP_ARRIVAL = 1'b0,
      OP_READ    = 1'b1
   } op_type;

   // Time arithmetic: seconds * 10^9 + nanoseconds fits in 62 bits.
   localparam int TIME_WIDTH = 62;
   localparam int GAP_WIDTH  = 40;
   localparam logic [STAMP_NS_WIDTH-1:0] NS_PER_SECOND = 30'd1000000000;

endpackage

`default_nettype wire

[src/iah_if.sv]
// ============================================================================
// Inter-arrival histogram channels
// Valid/ready channel interfaces for request and response transactions.
// ============================================================================
`default_nettype none

interface iah_req_if
   import iah_pkg::*;
   ();
   logic                        valid;
   logic                        ready;
   logic                        operation;
   logic [STAMP_SEC_WIDTH-1:0]  stamp_seconds;
   logic [STAMP_NS_WIDTH-1:0]   stamp_nanoseconds;
   logic [READ_INDEX_WIDTH-1:0] read_index;

   modport source (
      output valid, operation, stamp_seconds, stamp_nanoseconds, read_index,
      input  ready
   );
   modport sink (
      input  valid, operation, stamp_seconds, stamp_nanoseconds, read_index,
      output ready
   );
endinterface

interface iah_rsp_if
   import iah_pkg::*;
   ();
   logic                       valid;
   logic                       ready;
   logic [BIN_INDEX_WIDTH-1:0] bin_index;
   logic [BIN_COUNT_WIDTH-1:0] bin_count;
   logic                       recorded;

   modport source (
      output valid, bin_index, bin_count, recorded,
      input  ready
   );
   modport sink (
      input  valid, bin_index, bin_count, recorded,
      output ready
   );
endinterface

`default_nettype wire

[src/inter_arrival_histogram.sv]
// ============================================================================
// Inter-arrival histogram
// Bins the time between frame arrivals and keeps a saturating count per bin.
// ============================================================================
// Usage: the request channel carries either a frame arrival with a seconds and
// nanoseconds timestamp, or a read of one bin. Every request transaction
// produces exactly one response transaction on the response channel, in order.
// An arrival converts its timestamp to nanoseconds, takes the absolute gap to
// the previous arrival, maps it to a bin and increments that bin in the count
// RAM by read-modify-write. The first arrival after reset only stores its time.
// Requests are handled one at a time; the next request is taken once the last
// response has moved to the output register. A read passes the sequencer
// states for the RAM read and the update; an arrival passes those for the time
// multiply, the time sum, the gap, the offset, the scale multiply, the bin
// clamp, the RAM read and the update. The first arrival after reset skips the
// binning stages and goes from the gap state to its response.
// A finished response waits in an output register; the block accepts the next
// request while it waits and holds only when a second response is ready.
// After reset the block clears the count RAM, one entry per cycle, until all
// BIN_COUNT entries are zero; no request is taken during that time, but
// configuration writes are.
// ============================================================================
`default_nettype none

module inter_arrival_histogram
   import iah_pkg::*;
#(
   parameter int BIN_COUNT   = BIN_COUNT_DEFAULT,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   iah_req_if.sink                         req_ch,
   iah_rsp_if.source                       rsp_ch,
   input  wire logic                       csr_wr_en,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wr_data
);

   localparam int IDX_W   = $clog2(BIN_COUNT);
   localparam int PROD_W  = GAP_WIDTH + SCALE_WIDTH / 2;
   localparam int RAW_W   = PROD_W + 1 - 24;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_GAP,
      ST_OFS,
      ST_SCL,
      ST_BIN,
      ST_RD,
      ST_UPD,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [MIN_WIDTH-1:0]   min_ff;
   logic [SCALE_WIDTH-1:0] scale_ff;
   logic [BINS_WIDTH-1:0]  bins_ff;

   // Control state.
   logic             have_prev_ff;
   logic [IDX_W-1:0] clr_ff;
   logic             rsp_valid_ff;

   // Datapath registers.
   logic                        op_ff;
   logic [STAMP_SEC_WIDTH-1:0]  sec_ff;
   logic [STAMP_NS_WIDTH-1:0]   ns_ff;
   logic [READ_INDEX_WIDTH-1:0] ridx_ff;
   logic                        oob_ff;
   logic [TIME_WIDTH-1:0]       prod_ff;
   logic [TIME_WIDTH-1:0]       tnow_ff;
   logic [TIME_WIDTH-1:0]       tprev_ff;
   logic [GAP_WIDTH-1:0]        gap_ff;
   logic [GAP_WIDTH-1:0]        dist_ff;
   logic [PROD_W-1:0]           hi_ff;
   logic [PROD_W-1:0]           lo_ff;
   logic [IDX_W-1:0]            bin_ff;
   logic [BIN_INDEX_WIDTH-1:0]  res_index_ff;
   logic [BIN_COUNT_WIDTH-1:0]  res_count_ff;
   logic                        res_rec_ff;
   logic [BIN_INDEX_WIDTH-1:0]  rsp_index_ff;
   logic [BIN_COUNT_WIDTH-1:0]  rsp_count_ff;
   logic                        rsp_rec_ff;

   // Count RAM ports.
   logic                   mem_wr_en;
   logic [IDX_W-1:0]       mem_wr_addr;
   logic [COUNT_WIDTH-1:0] mem_wr_data;
   logic                   mem_rd_en;
   logic [COUNT_WIDTH-1:0] mem_rd_data;

   // Combinational datapath.
   logic                   req_fire;
   logic                   rsp_free;
   logic [TIME_WIDTH:0]    diff_fw;
   logic [TIME_WIDTH:0]    diff_bw;
   logic [TIME_WIDTH-1:0]  gap_abs;
   logic [GAP_WIDTH-1:0]   gap_sat;
   logic [GAP_WIDTH:0]     ofs_diff;
   logic [PROD_W:0]        scaled;
   logic [RAW_W-1:0]       raw_bin;
   logic [BINS_WIDTH-1:0]  bins_eff;
   logic [IDX_W-1:0]       lim_m1;
   logic [IDX_W-1:0]       bin_clamped;
   logic [COUNT_WIDTH-1:0] count_inc;
   logic [63:0]            count_ext;
   logic [31:0]            bin_ext;

   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.bin_index = rsp_index_ff;
   assign rsp_ch.bin_count = rsp_count_ff;
   assign rsp_ch.recorded  = rsp_rec_ff;

   // Absolute gap: both differences in parallel, the borrow picks one.
   assign diff_fw = {1'b0, tnow_ff} - {1'b0, tprev_ff};
   assign diff_bw = {1'b0, tprev_ff} - {1'b0, tnow_ff};
   assign gap_abs = diff_fw[TIME_WIDTH] ? diff_bw[TIME_WIDTH-1:0]
                                        : diff_fw[TIME_WIDTH-1:0];
   assign gap_sat = (|gap_abs[TIME_WIDTH-1:GAP_WIDTH]) ? {GAP_WIDTH{1'b1}}
                                                       : gap_abs[GAP_WIDTH-1:0];

   // A gap at or below the lower edge gives a zero distance and so bin zero.
   assign ofs_diff = {1'b0, gap_ff} - (GAP_WIDTH+1)'(min_ff);

   // floor(dist * scale / 2^40) from the two 16-bit partial products.
   assign scaled  = (PROD_W+1)'(hi_ff) + (PROD_W+1)'(lo_ff[PROD_W-1:16]);
   assign raw_bin = scaled[PROD_W:24];

   assign bins_eff = (bins_ff == '0) ? BINS_WIDTH'(1) : bins_ff;

   always_comb begin
      if (32'(bins_eff) > 32'(BIN_COUNT)) begin
         lim_m1 = IDX_W'(BIN_COUNT - 1);
      end else begin
         lim_m1 = IDX_W'(bins_eff - BINS_WIDTH'(1));
      end
      if (raw_bin > RAW_W'(lim_m1)) begin
         bin_clamped = lim_m1;
      end else begin
         bin_clamped = raw_bin[IDX_W-1:0];
      end
   end

   assign count_inc = (mem_rd_data == {COUNT_WIDTH{1'b1}}) ? mem_rd_data
                                                           : mem_rd_data + COUNT_WIDTH'(1);
   assign bin_ext   = 32'(bin_ff);

   always_comb begin
      if (op_ff == OP_READ) begin
         count_ext = oob_ff ? 64'd0 : 64'(mem_rd_data);
      end else begin
         count_ext = 64'(count_inc);
      end
   end

   // RAM access: the clearing pass, one read and one write per counted arrival,
   // and one read per read request. Requests are serialized, so a write always lands before the next read.
   assign mem_wr_en   = (state_ff == ST_CLEAR) || (state_ff == ST_UPD && op_ff == OP_ARRIVAL);
   assign mem_wr_addr = (state_ff == ST_CLEAR) ? clr_ff : bin_ff;
   assign mem_wr_data = (state_ff == ST_CLEAR) ? '0 : count_inc;
   assign mem_rd_en   = (state_ff == ST_RD);

   iah_ram #(
      .DEPTH (BIN_COUNT),
      .WIDTH (COUNT_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (bin_ff),
      .rd_data (mem_rd_data)
   );

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff   <= MIN_RESET;
         scale_ff <= SCALE_RESET;
         bins_ff  <= BINS_RESET;
      end else if (csr_wr_en) begin
         unique case (cfg_index_type'(csr_index))
            CFG_MIN_INTERVAL: min_ff   <= csr_wr_data[MIN_WIDTH-1:0];
            CFG_BIN_SCALE:    scale_ff <= csr_wr_data[SCALE_WIDTH-1:0];
            CFG_BINS_IN_USE:  bins_ff  <= csr_wr_data[BINS_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == IDX_W'(BIN_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_ch.operation == OP_READ) ? ST_RD : ST_MUL;
            end
         end
         ST_MUL:  state_in = ST_SUM;
         ST_SUM:  state_in = ST_GAP;
         ST_GAP:  state_in = have_prev_ff ? ST_OFS : ST_DONE;
         ST_OFS:  state_in = ST_SCL;
         ST_SCL:  state_in = ST_BIN;
         ST_BIN:  state_in = ST_RD;
         ST_RD:   state_in = ST_UPD;
         ST_UPD:  state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer state and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         have_prev_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + IDX_W'(1);
         end
         if (state_ff == ST_GAP) begin
            have_prev_ff <= 1'b1;
         end
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_ff   <= req_ch.operation;
               sec_ff  <= req_ch.stamp_seconds;
               ns_ff   <= req_ch.stamp_nanoseconds;
               ridx_ff <= req_ch.read_index;
               oob_ff  <= !(32'(req_ch.read_index) < 32'(BIN_COUNT));
               bin_ff  <= IDX_W'(req_ch.read_index);
            end
         end
         ST_MUL: prod_ff <= TIME_WIDTH'(sec_ff) * TIME_WIDTH'(NS_PER_SECOND);
         ST_SUM: tnow_ff <= prod_ff + TIME_WIDTH'(ns_ff);
         ST_GAP: begin
            gap_ff       <= gap_sat;
            tprev_ff     <= tnow_ff;
            res_index_ff <= '0;
            res_count_ff <= '0;
            res_rec_ff   <= 1'b0;
         end
         ST_OFS: dist_ff <= ofs_diff[GAP_WIDTH] ? '0 : ofs_diff[GAP_WIDTH-1:0];
         ST_SCL: begin
            hi_ff <= PROD_W'(dist_ff) * PROD_W'(scale_ff[SCALE_WIDTH-1:SCALE_WIDTH/2]);
            lo_ff <= PROD_W'(dist_ff) * PROD_W'(scale_ff[SCALE_WIDTH/2-1:0]);
         end
         ST_BIN: bin_ff <= bin_clamped;
         ST_UPD: begin
            res_index_ff <= (op_ff == OP_READ) ? ridx_ff : bin_ext[BIN_INDEX_WIDTH-1:0];
            res_count_ff <= count_ext[BIN_COUNT_WIDTH-1:0];
            res_rec_ff   <= (op_ff == OP_ARRIVAL);
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_index_ff <= res_index_ff;
               rsp_count_ff <= res_count_ff;
               rsp_rec_ff   <= res_rec_ff;
            end
         end
         default: ;
      endcase
   end

   // The count RAM is written only by the clearing pass or an arrival update.
   a_write_source: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (state_ff == ST_CLEAR) || (state_ff == ST_UPD && op_ff == OP_ARRIVAL))
      else $error("count RAM written outside clear or update");

   // No request is taken until the clearing pass is over.
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ch.ready)
      else $error("request accepted during clearing pass");

   // A counted arrival lands inside the bins in use.
   a_bin_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.recorded) |-> (32'(rsp_ch.bin_index) <= 32'(lim_m1)))
      else $error("recorded bin beyond clamp limit");

   // Once an arrival has been seen, the previous time stays valid.
   a_prev_holds: assert property (@(posedge clock)
      (!reset && !$past(reset)) |-> !$fell(have_prev_ff))
      else $error("previous arrival lost without reset");

endmodule

`default_nettype wire

[src/iah_ram.sv]
// ============================================================================
// Inter-arrival histogram count memory
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
`default_nettype none

module iah_ram #(
   parameter int DEPTH = 128,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire
